[rtl/lcst_pkg.sv]
// shared types, constants and helpers for the leg contact state tracker
// no dependencies; imported by every module of the block
package lcst_pkg;

   localparam int LEGS    = 4;
   localparam int DT_W    = 12;
   localparam int TIME_W  = 24;
   localparam int ACT_W   = 17;
   localparam int FORCE_W = 15;
   localparam int DVD_W   = 29;
   localparam int DVS_W   = 25;
   localparam int STEP_W  = 29;

   localparam logic [ACT_W-1:0]  ONE_Q16              = 17'd65536;
   localparam logic [ACT_W-1:0]  MIN_HOLD_ACTIVATION  = 17'd19661;
   localparam logic [TIME_W-1:0] T24_MAX              = 24'hFFFFFF;
   localparam logic [TIME_W-1:0] ASSUME_TIME          = 24'd40000;
   localparam logic [TIME_W-1:0] GRACE_TIME           = 24'd60000;
   localparam logic [TIME_W-1:0] RELEASE_TIME         = 24'd20000;
   localparam logic [TIME_W-1:0] MAX_UNSUPPORTED_TIME = 24'd100000;
   localparam logic [15:0]       MAX_STEP_TIME        = 16'd4095;

   localparam logic [1:0] PH_SWING   = 2'd0;
   localparam logic [1:0] PH_PENDING = 2'd1;
   localparam logic [1:0] PH_STANCE  = 2'd2;
   localparam logic [1:0] PH_LIFTOFF = 2'd3;

   localparam logic [2:0] REG_ENTER       = 3'd0;
   localparam logic [2:0] REG_EXIT        = 3'd1;
   localparam logic [2:0] REG_TAU         = 3'd2;
   localparam logic [2:0] REG_CONFIRM     = 3'd3;
   localparam logic [2:0] REG_LOSS        = 3'd4;
   localparam logic [2:0] REG_TD_RAMP     = 3'd5;
   localparam logic [2:0] REG_LO_RAMP     = 3'd6;
   localparam logic [2:0] REG_MIN_SUPPORT = 3'd7;

   // divider operations: legs 0..3 filter, then the two ramp steps
   localparam logic [2:0] OP_FILT_FIRST = 3'd0;
   localparam logic [2:0] OP_TD_RAMP    = 3'd4;
   localparam logic [2:0] OP_LO_RAMP    = 3'd5;

   typedef struct packed {
      logic [15:0]       enter_thr;
      logic [15:0]       exit_thr;
      logic [TIME_W-1:0] tau;
      logic [TIME_W-1:0] confirm;
      logic [TIME_W-1:0] loss;
      logic [TIME_W-1:0] td_ramp;
      logic [TIME_W-1:0] lo_ramp;
      logic [2:0]        min_support;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        phase;
      logic [TIME_W-1:0] tip;
      logic [TIME_W-1:0] ct;
      logic [TIME_W-1:0] lt;
      logic [ACT_W-1:0]  act;
      logic              conf;
   } leg_type;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       div_store;
      logic       update;
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic div_busy;
      logic out_full;
   } sts_type;

   function automatic logic [TIME_W-1:0] add_sat24(input logic [TIME_W-1:0] a,
                                                   input logic [DT_W-1:0] dt);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {{(TIME_W+1-DT_W){1'b0}}, dt};
      return s[TIME_W] ? T24_MAX : s[TIME_W-1:0];
   endfunction

endpackage

[rtl/lcst_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// depends on lcst_pkg for operand widths
module lcst_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lcst_pkg::DVD_W-1:0] dividend,
   input  logic [lcst_pkg::DVS_W-1:0] divisor,
   output logic                      busy,
   output logic                      done,
   output logic [lcst_pkg::DVD_W-1:0] quotient
);
   import lcst_pkg::*;

   localparam int CNT_W = $clog2(DVD_W);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   trial, diff;

   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = diff[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[rtl/lcst_ctrl.sv]
// sequencer: accept a tick, run six divisions, then write back the legs
// depends on lcst_pkg for the command and status structs
module lcst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcst_pkg::sts_type sts,
   output lcst_pkg::cmd_type cmd
);
   import lcst_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_START  = 2'd1;
   localparam logic [1:0] ST_WAIT   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = OP_FILT_FIRST;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (op_ff == OP_LO_RAMP) begin
                  state_in = ST_UPDATE;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_UPDATE: begin
            if (!sts.out_full) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_FILT_FIRST;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end
endmodule

[rtl/lcst_datapath.sv]
// tick registers, force filter, ramp steps, per-leg machines and result register
// depends on lcst_pkg and lcst_div
module lcst_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  lcst_pkg::cmd_type           cmd,
   input  lcst_pkg::cfg_type           cfg,
   output lcst_pkg::sts_type           sts,
   input  logic [3:0]                  req_planned_mask,
   input  logic signed [15:0]          req_force_leg0,
   input  logic signed [15:0]          req_force_leg1,
   input  logic signed [15:0]          req_force_leg2,
   input  logic signed [15:0]          req_force_leg3,
   input  logic [15:0]                 req_step_time,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg0,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg1,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg2,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg3,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg0,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg1,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg2,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg3,
   output logic [3:0]                  rsp_confirmed_mask,
   output logic [3:0]                  rsp_hard_contact_mask,
   output logic [7:0]                  rsp_leg_states,
   output logic                        rsp_healthy
);
   import lcst_pkg::*;

   // --- leg machine helpers
   function automatic leg_type go_to(input leg_type l, input logic [1:0] nx);
      leg_type r;
      r       = l;
      r.phase = nx;
      r.tip   = '0;
      r.ct    = '0;
      r.lt    = '0;
      if (nx == PH_SWING || nx == PH_PENDING) begin
         r.act  = '0;
         r.conf = 1'b0;
      end else if (nx == PH_STANCE && l.phase != PH_LIFTOFF) begin
         r.act = '0;
      end
      return r;
   endfunction

   function automatic leg_type leg_advance(input leg_type cur, input logic plan,
                                           input logic [FORCE_W-1:0] f,
                                           input logic [DT_W-1:0] dt,
                                           input cfg_type c,
                                           input logic [STEP_W-1:0] step);
      leg_type      r;
      logic         above, below;
      logic [29:0]  sum;
      above = {1'b0, f} >= c.enter_thr;
      below = {1'b0, f} <  c.exit_thr;
      r     = cur;
      r.tip = add_sat24(cur.tip, dt);
      case (cur.phase)
         PH_SWING: begin
            r.act = '0;
            if (plan) r = go_to(r, PH_PENDING);
         end
         PH_PENDING: begin
            r.act = '0;
            if (!plan) begin
               r = go_to(r, PH_SWING);
            end else begin
               r.ct = above ? add_sat24(cur.ct, dt) : '0;
               if (r.ct >= c.confirm) begin
                  r.conf = 1'b1;
                  r      = go_to(r, PH_STANCE);
               end else if (r.tip >= ASSUME_TIME) begin
                  r = go_to(r, PH_STANCE);
               end
            end
         end
         PH_STANCE: begin
            if (!plan) begin
               r = go_to(r, PH_LIFTOFF);
            end else if (!cur.conf) begin
               r.ct = above ? add_sat24(cur.ct, dt) : '0;
               if (r.ct >= c.confirm) r.conf = 1'b1;
               else if (r.tip >= GRACE_TIME) r = go_to(r, PH_PENDING);
            end else begin
               r.lt = below ? add_sat24(cur.lt, dt) : '0;
               if (r.lt >= c.loss) r = go_to(r, PH_PENDING);
            end
         end
         default: begin
            if (plan) r = go_to(r, PH_STANCE);
            else r.lt = below ? add_sat24(cur.lt, dt) : '0;
         end
      endcase
      if (r.phase == PH_STANCE) begin
         sum   = {13'b0, r.act} + {1'b0, step};
         r.act = (sum > {13'b0, ONE_Q16}) ? ONE_Q16 : sum[ACT_W-1:0];
      end
      return r;
   endfunction

   function automatic leg_type leg_release(input leg_type l, input logic ok,
                                           input logic [STEP_W-1:0] step);
      leg_type            r;
      logic signed [30:0] nxt;
      r   = l;
      nxt = $signed({14'b0, l.act}) - $signed({2'b0, step});
      if (l.phase == PH_LIFTOFF) begin
         if (!ok) begin
            r.act = (nxt > $signed({14'b0, MIN_HOLD_ACTIVATION})) ?
                    nxt[ACT_W-1:0] : MIN_HOLD_ACTIVATION;
         end else begin
            r.act = (nxt > 31'sd0) ? nxt[ACT_W-1:0] : '0;
            if (r.act == '0 || r.lt >= RELEASE_TIME) r = go_to(r, PH_SWING);
         end
      end
      return r;
   endfunction

   // --- tick registers
   logic [3:0]         planned_ff;
   logic [DT_W-1:0]    dt_ff, dt_in;
   logic [FORCE_W-1:0] x_ff [LEGS];
   logic [FORCE_W-1:0] x_in [LEGS];
   logic [FORCE_W-1:0] f_ff [LEGS];
   leg_type            leg_ff [LEGS];
   logic               started_ff;
   logic [TIME_W-1:0]  unsup_ff, unsup_in;
   logic [STEP_W-1:0]  step_td_ff, step_lo_ff;
   logic               neg_ff;
   logic               rsp_valid_ff;

   // --- divider operands
   logic [1:0]          leg_sel;
   logic signed [15:0]  diff;
   logic [FORCE_W-1:0]  abs_diff;
   logic [26:0]         prod_abs;
   logic [DVS_W-1:0]    den;
   logic [TIME_W-1:0]   ramp_t, ramp_t_st;
   logic [DVD_W-1:0]    dvd;
   logic [DVS_W-1:0]    dvs;
   logic                div_busy, div_done;
   logic [DVD_W-1:0]    quot;
   logic [15:0]         q;
   logic [16:0]         f_sum;

   assign dt_in = (req_step_time > MAX_STEP_TIME) ? MAX_STEP_TIME[DT_W-1:0] :
                  req_step_time[DT_W-1:0];
   assign x_in[0] = req_force_leg0[15] ? '0 : req_force_leg0[FORCE_W-1:0];
   assign x_in[1] = req_force_leg1[15] ? '0 : req_force_leg1[FORCE_W-1:0];
   assign x_in[2] = req_force_leg2[15] ? '0 : req_force_leg2[FORCE_W-1:0];
   assign x_in[3] = req_force_leg3[15] ? '0 : req_force_leg3[FORCE_W-1:0];

   assign leg_sel   = cmd.op[1:0];
   assign den       = {1'b0, cfg.tau} + {{(DVS_W-DT_W){1'b0}}, dt_ff};
   assign ramp_t    = (cmd.op == OP_TD_RAMP) ? cfg.td_ramp : cfg.lo_ramp;
   assign ramp_t_st = (cmd.op == OP_TD_RAMP) ? cfg.td_ramp : cfg.lo_ramp;

   always_comb begin
      diff     = $signed({1'b0, x_ff[leg_sel]}) - $signed({1'b0, f_ff[leg_sel]});
      abs_diff = diff[15] ? FORCE_W'(-diff) : diff[FORCE_W-1:0];
      prod_abs = dt_ff * abs_diff;
      if (cmd.op >= OP_TD_RAMP) begin
         dvd = {1'b0, dt_ff, 16'b0} + {5'b0, ramp_t >> 1};
         dvs = {1'b0, ramp_t};
      end else begin
         dvd = {2'b0, prod_abs} + {4'b0, den >> 1};
         dvs = den;
      end
   end

   lcst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quot)
   );

   // filter correction: zero denominator leaves the force as it is
   assign q     = (den == '0) ? 16'd0 : quot[15:0];
   assign f_sum = neg_ff ? ({2'b0, f_ff[leg_sel]} - {1'b0, q}) :
                           ({2'b0, f_ff[leg_sel]} + {1'b0, q});

   // --- leg update, all four legs at once
   leg_type    leg_a   [LEGS];
   leg_type    leg_b   [LEGS];
   logic [2:0] nplanned, nsupport, required;
   logic       transfer_ok;

   always_comb begin
      nplanned = '0;
      nsupport = '0;
      for (int i = 0; i < LEGS; i++) begin
         leg_a[i] = leg_advance(leg_ff[i], planned_ff[i], f_ff[i], dt_ff, cfg,
                                step_td_ff);
         if (planned_ff[i]) begin
            nplanned = nplanned + 1'b1;
            if (leg_a[i].phase == PH_STANCE && leg_a[i].conf)
               nsupport = nsupport + 1'b1;
         end
      end
      required    = (cfg.min_support < nplanned) ? cfg.min_support : nplanned;
      transfer_ok = (required == '0) || (nsupport >= required);
      for (int i = 0; i < LEGS; i++)
         leg_b[i] = leg_release(leg_a[i], transfer_ok, step_lo_ff);
      unsup_in = (nplanned != '0 && !transfer_ok) ? add_sat24(unsup_ff, dt_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         unsup_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LEGS; i++) begin
            leg_ff[i] <= '0;
            f_ff[i]   <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.load && !started_ff) begin
            started_ff <= 1'b1;
            for (int i = 0; i < LEGS; i++) f_ff[i] <= x_in[i];
         end
         if (cmd.div_store && cmd.op < OP_TD_RAMP)
            f_ff[leg_sel] <= f_sum[FORCE_W-1:0];
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
            unsup_ff     <= unsup_in;
            for (int i = 0; i < LEGS; i++) leg_ff[i] <= leg_b[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         planned_ff <= req_planned_mask;
         dt_ff      <= dt_in;
         for (int i = 0; i < LEGS; i++) x_ff[i] <= x_in[i];
      end
      if (cmd.div_start) neg_ff <= diff[15];
      if (cmd.div_store && cmd.op == OP_TD_RAMP)
         step_td_ff <= (ramp_t_st == '0) ? STEP_W'(ONE_Q16) : quot;
      if (cmd.div_store && cmd.op == OP_LO_RAMP)
         step_lo_ff <= (ramp_t_st == '0) ? STEP_W'(ONE_Q16) : quot;
      if (cmd.update) begin
         rsp_activation_leg0   <= leg_b[0].act;
         rsp_activation_leg1   <= leg_b[1].act;
         rsp_activation_leg2   <= leg_b[2].act;
         rsp_activation_leg3   <= leg_b[3].act;
         rsp_filtered_leg0     <= f_ff[0];
         rsp_filtered_leg1     <= f_ff[1];
         rsp_filtered_leg2     <= f_ff[2];
         rsp_filtered_leg3     <= f_ff[3];
         rsp_confirmed_mask    <= {leg_b[3].conf, leg_b[2].conf, leg_b[1].conf,
                                   leg_b[0].conf};
         rsp_hard_contact_mask <= {leg_b[3].phase[1], leg_b[2].phase[1],
                                   leg_b[1].phase[1], leg_b[0].phase[1]};
         rsp_leg_states        <= {leg_b[3].phase, leg_b[2].phase, leg_b[1].phase,
                                   leg_b[0].phase};
         rsp_healthy           <= (unsup_in <= MAX_UNSUPPORTED_TIME);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign sts.div_done = div_done;
   assign sts.div_busy = div_busy;
   assign sts.out_full = rsp_valid_ff && rsp_stall;
endmodule

[rtl/leg_contact_state_tracker.sv]
// each accepted tick makes six passes through the shared 29-step divider (four filter
// corrections, two ramp steps) and then one update that loads its result beat
// ticks are taken one at a time; a tick is taken while a result beat waits
// downstream, but its update then waits until that beat has left
// reset (synchronous, active high) loads register defaults, puts every leg in swing
// and clears timers, activations, filter state and the health timer
module leg_contact_state_tracker (
   input  logic                        clock,
   input  logic                        reset,
   // input tick channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_planned_mask,
   input  logic signed [15:0]          req_force_leg0,
   input  logic signed [15:0]          req_force_leg1,
   input  logic signed [15:0]          req_force_leg2,
   input  logic signed [15:0]          req_force_leg3,
   input  logic [15:0]                 req_step_time,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg0,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg1,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg2,
   output logic [lcst_pkg::ACT_W-1:0]   rsp_activation_leg3,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg0,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg1,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg2,
   output logic [lcst_pkg::FORCE_W-1:0] rsp_filtered_leg3,
   output logic [3:0]                  rsp_confirmed_mask,
   output logic [3:0]                  rsp_hard_contact_mask,
   output logic [7:0]                  rsp_leg_states,
   output logic                        rsp_healthy,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [4:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import lcst_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   sts_type    sts;
   logic       csr_write;
   logic [2:0] csr_index;

   // register i sits at byte address 4*i
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enter_thr   <= 16'd2000;
         cfg_ff.exit_thr    <= 16'd800;
         cfg_ff.tau         <= 24'd10000;
         cfg_ff.confirm     <= 24'd20000;
         cfg_ff.loss        <= 24'd30000;
         cfg_ff.td_ramp     <= 24'd50000;
         cfg_ff.lo_ramp     <= 24'd50000;
         cfg_ff.min_support <= 3'd2;
      end else if (csr_write) begin
         case (csr_index)
            REG_ENTER:       cfg_ff.enter_thr   <= pwdata[15:0];
            REG_EXIT:        cfg_ff.exit_thr    <= pwdata[15:0];
            REG_TAU:         cfg_ff.tau         <= pwdata[TIME_W-1:0];
            REG_CONFIRM:     cfg_ff.confirm     <= pwdata[TIME_W-1:0];
            REG_LOSS:        cfg_ff.loss        <= pwdata[TIME_W-1:0];
            REG_TD_RAMP:     cfg_ff.td_ramp     <= pwdata[TIME_W-1:0];
            REG_LO_RAMP:     cfg_ff.lo_ramp     <= pwdata[TIME_W-1:0];
            REG_MIN_SUPPORT: cfg_ff.min_support <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   // read back, zero extended
   always_comb begin
      case (csr_index)
         REG_ENTER:       prdata = {16'b0, cfg_ff.enter_thr};
         REG_EXIT:        prdata = {16'b0, cfg_ff.exit_thr};
         REG_TAU:         prdata = {8'b0, cfg_ff.tau};
         REG_CONFIRM:     prdata = {8'b0, cfg_ff.confirm};
         REG_LOSS:        prdata = {8'b0, cfg_ff.loss};
         REG_TD_RAMP:     prdata = {8'b0, cfg_ff.td_ramp};
         REG_LO_RAMP:     prdata = {8'b0, cfg_ff.lo_ramp};
         REG_MIN_SUPPORT: prdata = {29'b0, cfg_ff.min_support};
         default:         prdata = '0;
      endcase
   end

   // sequencer: load, six divisions, update
   lcst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // filter, leg machines and the result register
   lcst_datapath u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .cfg                   (cfg_ff),
      .sts                   (sts),
      .req_planned_mask      (req_planned_mask),
      .req_force_leg0        (req_force_leg0),
      .req_force_leg1        (req_force_leg1),
      .req_force_leg2        (req_force_leg2),
      .req_force_leg3        (req_force_leg3),
      .req_step_time         (req_step_time),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_activation_leg0   (rsp_activation_leg0),
      .rsp_activation_leg1   (rsp_activation_leg1),
      .rsp_activation_leg2   (rsp_activation_leg2),
      .rsp_activation_leg3   (rsp_activation_leg3),
      .rsp_filtered_leg0     (rsp_filtered_leg0),
      .rsp_filtered_leg1     (rsp_filtered_leg1),
      .rsp_filtered_leg2     (rsp_filtered_leg2),
      .rsp_filtered_leg3     (rsp_filtered_leg3),
      .rsp_confirmed_mask    (rsp_confirmed_mask),
      .rsp_hard_contact_mask (rsp_hard_contact_mask),
      .rsp_leg_states        (rsp_leg_states),
      .rsp_healthy           (rsp_healthy)
   );

`ifndef NO_ASSERTIONS
   // a taken tick closes the input side while it is worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again right after a tick");

   // the shared divider is never restarted mid-division
   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   // hard contact follows the upper phase bit of each leg
   a_hard_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hard_contact_mask == {rsp_leg_states[7], rsp_leg_states[5],
                                                rsp_leg_states[3], rsp_leg_states[1]}))
      else $error("hard contact mask disagrees with leg states");

   // activation never exceeds one
   a_act_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_activation_leg0 <= ONE_Q16 && rsp_activation_leg1 <= ONE_Q16 &&
                     rsp_activation_leg2 <= ONE_Q16 && rsp_activation_leg3 <= ONE_Q16))
      else $error("activation above one");
`endif
endmodule
